/* hdl/pcbd_pkg.sv */
// ----------------------------------------------------------------------------
// pcbd_pkg
// Shared types and constants of the prefix code bit decoder.
// ----------------------------------------------------------------------------
package pcbd_pkg;

	// command codes carried in the input tuser
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// fixed field widths
	localparam int SYM_OUT_W = 8;
	localparam int CODE_W    = 16;
	localparam int LEN_W     = 5;
	localparam int CMP_W     = 6;
	localparam int IN_DATA_W = 32;

	// bit positions of the input tdata fields
	localparam int SYM_LSB  = 0;
	localparam int CODE_LSB = 8;
	localparam int LEN_LSB  = 24;
	localparam int BIT_LSB  = 29;

	// one table entry as read back by the scan
	typedef struct packed {
		logic              vld;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_rd_t;

	// stored part of an entry
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

endpackage

/* hdl/pcbd_table.sv */
// ----------------------------------------------------------------------------
// pcbd_table
// Code table memory: one write port for loads, one registered read port for
// the scan, with a valid bit per entry that reset clears.
// ----------------------------------------------------------------------------
module pcbd_table #(
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [$clog2(SYMBOL_COUNT)-1:0]      wr_addr,
	input  pcbd_pkg::entry_t                     wr_entry,
	input  logic                                 rd_en,
	input  logic [$clog2(SYMBOL_COUNT)-1:0]      rd_addr,
	output pcbd_pkg::tbl_rd_t                    rd_data
);

	pcbd_pkg::entry_t        mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] vld_q;
	pcbd_pkg::entry_t        rd_entry_q;
	logic                    rd_vld_q;

	// entry storage, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	// valid bits, an unwritten entry reads as unused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data.vld  = rd_vld_q;
	assign rd_data.code = rd_entry_q.code;
	assign rd_data.len  = rd_entry_q.len;

endmodule

/* hdl/pcbd_match.sv */
// ----------------------------------------------------------------------------
// pcbd_match
// Shared comparator: checks one table entry against the running prefix.
// ----------------------------------------------------------------------------
module pcbd_match (
	input  pcbd_pkg::tbl_rd_t                entry,
	input  logic [pcbd_pkg::CODE_W-1:0]      prefix_bits,
	input  logic [pcbd_pkg::CMP_W-1:0]       prefix_count,
	output logic                             hit
);

	logic [pcbd_pkg::CODE_W-1:0] mask;
	logic                        len_ok;

	// mask of the low len bits
	always_comb begin
		for (int i = 0; i < pcbd_pkg::CODE_W; i++) begin
			mask[i] = (pcbd_pkg::CMP_W'(i) < {1'b0, entry.len});
		end
	end

	// used entry, at most code width, same length as the prefix
	assign len_ok = entry.vld && (entry.len != '0)
		&& ({1'b0, entry.len} <= pcbd_pkg::CMP_W'(pcbd_pkg::CODE_W))
		&& ({1'b0, entry.len} == prefix_count);

	assign hit = len_ok && (((entry.code ^ prefix_bits) & mask) == '0);

endmodule

/* hdl/prefix_code_bit_decoder.sv */
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder
// Bit-serial prefix code decoder with a loadable code table.
//
//  channel | dir | tdata                                         | tuser
//  s_axis  | in  | symbol, code_value, code_length, code_bit     | command
//  m_axis  | out | decoded_symbol                                | overflow
//
// A load beat writes the table memory while the sequencer is idle. In a decode
// beat one shared comparator checks the table entries one per cycle through
// the registered read port of the table memory, then the result is registered.
// The scan stops early at the first matching entry (lowest symbol wins).
// Reset clears the prefix and all table valid bits at once; no clearing pass.
// A new result that finds the output register still full on a stalled m_axis
// holds the sequencer until the older beat is taken.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// symbol[7:0], code_value[23:8], code_length[28:24], code_bit[29], zero fill
	input  logic [pcbd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// command[0]
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// decoded_symbol[7:0]
	output logic [pcbd_pkg::SYM_OUT_W-1:0]     m_axis_tdata,
	// overflow[0]
	output logic                               m_axis_tuser
);

	localparam int SYM_W = $clog2(SYMBOL_COUNT);
	localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
	localparam logic [SYM_W-1:0] LAST_ADDR = SYM_W'(SYMBOL_COUNT - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                          state_q;
	logic [pcbd_pkg::CODE_W-1:0]         bits_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [SYM_W-1:0]                    addr_q;
	logic                                issue_q;
	logic                                rd_vld_s1;
	logic [SYM_W-1:0]                    addr_s1;
	logic [pcbd_pkg::SYM_OUT_W-1:0]      res_sym_q;
	logic                                res_ovf_q;
	logic                                out_vld_q;
	logic [pcbd_pkg::SYM_OUT_W-1:0]      out_sym_q;
	logic                                out_ovf_q;

	logic                                in_beat;
	logic                                load_beat;
	logic                                in_sym_ok;
	pcbd_pkg::entry_t                    wr_entry;
	pcbd_pkg::tbl_rd_t                   rd_data;
	logic                                rd_en;
	logic                                hit;
	logic                                scan_end;
	logic                                cnt_full;

	// input beat decode
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign load_beat     = in_beat && (s_axis_tuser == pcbd_pkg::CMD_LOAD);
	assign in_sym_ok     = ({1'b0, s_axis_tdata[pcbd_pkg::SYM_LSB +: pcbd_pkg::SYM_OUT_W]}
		< 9'(SYMBOL_COUNT));
	assign wr_entry.code = s_axis_tdata[pcbd_pkg::CODE_LSB +: pcbd_pkg::CODE_W];
	assign wr_entry.len  = s_axis_tdata[pcbd_pkg::LEN_LSB +: pcbd_pkg::LEN_W];

	// code table
	assign rd_en = (state_q == ST_SCAN) && issue_q;

	pcbd_table #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (load_beat && in_sym_ok),
		.wr_addr  (s_axis_tdata[pcbd_pkg::SYM_LSB +: SYM_W]),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (addr_q),
		.rd_data  (rd_data)
	);

	// shared comparator
	pcbd_match u_match (
		.entry        (rd_data),
		.prefix_bits  (bits_q),
		.prefix_count (pcbd_pkg::CMP_W'(cnt_q)),
		.hit          (hit)
	);

	assign scan_end = rd_vld_s1 && (hit || (addr_s1 == LAST_ADDR));
	assign cnt_full = (cnt_q >= CNT_W'(MAX_CODE_LEN));

	// sequencer, prefix and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bits_q    <= '0;
			cnt_q     <= '0;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			addr_s1   <= '0;
			res_sym_q <= '0;
			res_ovf_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_beat && (s_axis_tuser == pcbd_pkg::CMD_DECODE)) begin
						bits_q  <= {bits_q[pcbd_pkg::CODE_W-2:0], s_axis_tdata[pcbd_pkg::BIT_LSB]};
						cnt_q   <= cnt_q + 1'b1;
						addr_q  <= '0;
						issue_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						issue_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
						if (hit) begin
							res_sym_q <= pcbd_pkg::SYM_OUT_W'(addr_s1);
							res_ovf_q <= 1'b0;
							bits_q    <= '0;
							cnt_q     <= '0;
							state_q   <= ST_EMIT;
						end else if (cnt_full) begin
							res_sym_q <= '0;
							res_ovf_q <= 1'b1;
							bits_q    <= '0;
							cnt_q     <= '0;
							state_q   <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						rd_vld_s1 <= issue_q;
						addr_s1   <= addr_q;
						if (issue_q) begin
							if (addr_q == LAST_ADDR) begin
								issue_q <= 1'b0;
							end else begin
								addr_q <= addr_q + 1'b1;
							end
						end
					end
				end
				ST_EMIT: begin
					if (!out_vld_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && (!out_vld_q || m_axis_tready)) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && (!out_vld_q || m_axis_tready)) begin
			out_sym_q <= res_sym_q;
			out_ovf_q <= res_ovf_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_sym_q;
	assign m_axis_tuser  = out_ovf_q;

`ifndef NO_ASSERTIONS
	// an overflow beat carries symbol zero
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("overflow beat with nonzero symbol");

	// the prefix is cleared once a result is on its way
	a_prefix_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> cnt_q == '0 && bits_q == '0)
		else $error("prefix not cleared with a pending result");

	// prefix count stays below the overflow limit between beats
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_q < CNT_W'(MAX_CODE_LEN))
		else $error("prefix count at limit while idle");

	// a load leaves the prefix alone
	a_load_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		load_beat |=> $stable(cnt_q) && $stable(bits_q))
		else $error("load changed the prefix");

	// the read stage only follows an issued address
	a_rd_follow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(rd_en))
		else $error("read stage valid without an issued read");
`endif

endmodule

/* tb/sv/prefix_code_bit_decoder_checker.sv */
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_checker
// Watches both stream channels of the prefix code bit decoder, keeps its own
// copy of the code table and the running prefix, predicts the symbol or
// overflow beat that each decode beat causes and compares every output beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	// symbol[7:0], code_value[23:8], code_length[28:24], code_bit[29], zero fill
	input  logic [pcbd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// command[0]
	input  logic                               s_axis_tuser,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// decoded_symbol[7:0]
	input  logic [pcbd_pkg::SYM_OUT_W-1:0]     m_axis_tdata,
	// overflow[0]
	input  logic                               m_axis_tuser,
	output int                                 mismatches,
	output int                                 results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 256;
	localparam int LONGEST_CODE = 16;

	typedef struct packed {
		logic [pcbd_pkg::SYM_OUT_W-1:0] sym;
		logic                           ovf;
	} decode_result_t;

	// shadow code table and running prefix
	logic [pcbd_pkg::CODE_W-1:0] code_tbl [TABLE_DEPTH];
	logic [pcbd_pkg::LEN_W-1:0]  len_tbl [TABLE_DEPTH];
	logic [pcbd_pkg::CODE_W-1:0] prefix_val;
	int                          prefix_len;

	decode_result_t                 expected_syms [$];
	decode_result_t                 want;
	logic [pcbd_pkg::CODE_W-1:0]    mask;
	logic [pcbd_pkg::SYM_OUT_W-1:0] load_sym;
	bit                             hit;
	int                             mismatch_cnt;

	// outputs are compared before the input beat of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (len_tbl[i]) len_tbl[i] = '0;
			foreach (code_tbl[i]) code_tbl[i] = '0;
			prefix_val = '0;
			prefix_len = 0;
			expected_syms.delete();
			mismatch_cnt = 0;
		end else begin
			// output beat against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_syms.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual symbol %0d overflow %0b",
						$time, m_axis_tdata, m_axis_tuser);
					mismatch_cnt++;
				end else begin
					want = expected_syms.pop_front();
					if (m_axis_tdata !== want.sym) begin
						$display("%0t: decoded_symbol expected %0d actual %0d",
							$time, want.sym, m_axis_tdata);
						mismatch_cnt++;
					end
					if (m_axis_tuser !== want.ovf) begin
						$display("%0t: overflow expected %0b actual %0b",
							$time, want.ovf, m_axis_tuser);
						mismatch_cnt++;
					end
				end
			end

			// input beat: table write or one more prefix bit
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == pcbd_pkg::CMD_LOAD) begin
					load_sym = s_axis_tdata[pcbd_pkg::SYM_LSB +: pcbd_pkg::SYM_OUT_W];
					code_tbl[load_sym] = s_axis_tdata[pcbd_pkg::CODE_LSB +: pcbd_pkg::CODE_W];
					len_tbl[load_sym]  = s_axis_tdata[pcbd_pkg::LEN_LSB +: pcbd_pkg::LEN_W];
				end else begin
					prefix_val = {prefix_val[pcbd_pkg::CODE_W-2:0],
						s_axis_tdata[pcbd_pkg::BIT_LSB]};
					prefix_len++;
					hit = 1'b0;
					// lowest matching symbol wins
					for (int s = 0; s < TABLE_DEPTH && !hit; s++) begin
						if (len_tbl[s] != 0 && len_tbl[s] <= LONGEST_CODE &&
							len_tbl[s] == prefix_len) begin
							mask = pcbd_pkg::CODE_W'((32'd1 << len_tbl[s]) - 32'd1);
							if ((code_tbl[s] & mask) == (prefix_val & mask)) begin
								want.sym = pcbd_pkg::SYM_OUT_W'(s);
								want.ovf = 1'b0;
								expected_syms.push_back(want);
								hit = 1'b1;
							end
						end
					end
					// full length without a match drops the prefix
					if (!hit && prefix_len >= LONGEST_CODE) begin
						want.sym = '0;
						want.ovf = 1'b1;
						expected_syms.push_back(want);
						hit = 1'b1;
					end
					if (hit) begin
						prefix_val = '0;
						prefix_len = 0;
					end
				end
			end
		end
		mismatches      <= mismatch_cnt;
		results_pending <= expected_syms.size();
	end

endmodule

/* tb/sv/prefix_code_bit_decoder_tb.sv */
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder_tb
// Loads random prefix code tables (complete, incomplete and with duplicate or
// over-long entries) and streams encoded symbols with some noise bits, under
// random idle bursts on both channels. A checker beside the block predicts
// and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BEAT_TARGET  = 1900;
	localparam int QUIET_AFTER  = 1650;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_LEAVES   = 64;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [pcbd_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic                           s_axis_tuser = pcbd_pkg::CMD_LOAD;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [pcbd_pkg::SYM_OUT_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;

	int mismatches;
	int results_pending;
	int beats_sent = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit lull = 1'b0;

	// symbols holding a nonzero length in the table
	bit sym_used [256];

	// leaves of the code tree under construction
	logic [pcbd_pkg::CODE_W-1:0] leaf_val [MAX_LEAVES];
	int                          leaf_len [MAX_LEAVES];
	bit                          leaf_live [MAX_LEAVES];
	int                          leaf_cnt;
	int                          live_cnt;

	always #1 clk = ~clk;

	prefix_code_bit_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	prefix_code_bit_decoder_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	// output backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (!quiet && !lull && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [pcbd_pkg::IN_DATA_W-1:0] pack_fields(
		input logic [pcbd_pkg::SYM_OUT_W-1:0] sym,
		input logic [pcbd_pkg::CODE_W-1:0] value, input logic [pcbd_pkg::LEN_W-1:0] len,
		input logic cbit);
		logic [pcbd_pkg::IN_DATA_W-1:0] d;
		d = '0;
		d[pcbd_pkg::SYM_LSB +: pcbd_pkg::SYM_OUT_W] = sym;
		d[pcbd_pkg::CODE_LSB +: pcbd_pkg::CODE_W]   = value;
		d[pcbd_pkg::LEN_LSB +: pcbd_pkg::LEN_W]     = len;
		d[pcbd_pkg::BIT_LSB]                        = cbit;
		return d;
	endfunction

	// one input beat, with an optional idle burst ahead of it
	task automatic push_beat(input logic cmd, input logic [pcbd_pkg::IN_DATA_W-1:0] data);
		if (!quiet && !lull && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
		if (beats_sent >= QUIET_AFTER)
			quiet = 1'b1;
	endtask

	task automatic load_entry(input int sym, input logic [pcbd_pkg::CODE_W-1:0] value,
		input int len);
		push_beat(pcbd_pkg::CMD_LOAD, pack_fields(pcbd_pkg::SYM_OUT_W'(sym), value,
			pcbd_pkg::LEN_W'(len), 1'($urandom_range(0, 1))));
		sym_used[sym] = (len != 0);
	endtask

	// unused fields of a decode beat carry random bits
	task automatic decode_bit(input logic b);
		push_beat(pcbd_pkg::CMD_DECODE, pack_fields(pcbd_pkg::SYM_OUT_W'($urandom),
			pcbd_pkg::CODE_W'($urandom), pcbd_pkg::LEN_W'($urandom), b));
	endtask

	function automatic int fresh_symbol();
		int s;
		do s = $urandom_range(0, 255); while (sym_used[s]);
		return s;
	endfunction

	// one table: clear the old one unless stale entries are kept, build a code tree, load it, stream encoded symbols
	task automatic run_phase();
		int mode, target, lmax, idx, tries, used_cnt, n_bits, sent_here, roll, s;
		bit deep;
		logic [pcbd_pkg::CODE_W-1:0] mask;

		lull = ($urandom_range(0, 3) == 0);

		// mostly wipe the old table, sometimes keep stale entries around
		used_cnt = 0;
		foreach (sym_used[k]) used_cnt += int'(sym_used[k]);
		if (used_cnt > 150 || $urandom_range(0, 5) != 0) begin
			for (s = 0; s < 256; s++)
				if (sym_used[s])
					load_entry(s, pcbd_pkg::CODE_W'($urandom), 0);
		end

		// mode 0 empty table, 1..3 incomplete code, else complete code
		mode = $urandom_range(0, 9);
		leaf_cnt = 0;
		live_cnt = 0;
		if (mode != 0) begin
			leaf_val[0] = '0;
			leaf_len[0] = 1;
			leaf_val[1] = pcbd_pkg::CODE_W'(1);
			leaf_len[1] = 1;
			leaf_cnt = 2;
			deep = ($urandom_range(0, 2) == 0);
			lmax = (deep || $urandom_range(0, 3) == 0) ? 16 : $urandom_range(2, 10);
			target = deep ? $urandom_range(16, 40) : $urandom_range(2, 40);
			tries = 0;
			// split leaves until the target count or no room is left
			while (leaf_cnt < target && tries < 400) begin
				idx = (deep && leaf_len[leaf_cnt-1] < lmax) ? leaf_cnt - 1
					: $urandom_range(0, leaf_cnt - 1);
				if (leaf_len[idx] < lmax) begin
					leaf_val[leaf_cnt] = {leaf_val[idx][pcbd_pkg::CODE_W-2:0], 1'b1};
					leaf_len[leaf_cnt] = leaf_len[idx] + 1;
					leaf_val[idx] = {leaf_val[idx][pcbd_pkg::CODE_W-2:0], 1'b0};
					leaf_len[idx]++;
					leaf_cnt++;
				end
				tries++;
			end

			// load leaves, garbage above the code bits on some
			for (idx = 0; idx < leaf_cnt; idx++) begin
				leaf_live[idx] = (mode > 3) || ($urandom_range(0, 3) != 0);
				if (leaf_live[idx]) begin
					mask = pcbd_pkg::CODE_W'((32'd1 << leaf_len[idx]) - 32'd1);
					load_entry(fresh_symbol(), $urandom_range(0, 1) ? leaf_val[idx]
						: (leaf_val[idx] | (pcbd_pkg::CODE_W'($urandom) & ~mask)),
						leaf_len[idx]);
					live_cnt++;
				end
			end

			// duplicate code on another symbol
			if (live_cnt > 0 && $urandom_range(0, 2) == 0) begin
				do idx = $urandom_range(0, leaf_cnt - 1); while (!leaf_live[idx]);
				load_entry(fresh_symbol(), leaf_val[idx], leaf_len[idx]);
			end
			// entry too long to ever match
			if ($urandom_range(0, 2) == 0)
				load_entry(fresh_symbol(), pcbd_pkg::CODE_W'($urandom), $urandom_range(17, 31));
		end

		// encoded symbols with noise bits and stray loads in between
		n_bits = (mode == 0) ? $urandom_range(20, 50) : $urandom_range(80, 200);
		sent_here = 0;
		while (sent_here < n_bits && beats_sent < BEAT_TARGET) begin
			roll = $urandom_range(0, 39);
			if (roll == 0) begin
				load_entry($urandom_range(0, 255), pcbd_pkg::CODE_W'($urandom),
					($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16));
			end else if (live_cnt == 0 || roll < 5) begin
				decode_bit(1'($urandom_range(0, 1)));
				sent_here++;
			end else begin
				do idx = $urandom_range(0, leaf_cnt - 1); while (!leaf_live[idx]);
				for (int b = leaf_len[idx] - 1; b >= 0; b--)
					decode_bit(leaf_val[idx][b]);
				sent_here += leaf_len[idx];
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-ones code at full length, a one-bit code given with high garbage,
		// the same one-bit code on a lower symbol, and an over-long entry
		load_entry(0, 16'hFFFF, 16);
		load_entry(255, 16'hFFFE, 1);
		load_entry(7, 16'h0000, 1);
		load_entry(9, 16'h0001, 31);
		// lower symbol wins the duplicate
		decode_bit(1'b0);
		// full-length code decodes, with a load in the middle of the prefix
		repeat (8) decode_bit(1'b1);
		load_entry(3, 16'hFFFF, 17);
		repeat (8) decode_bit(1'b1);

		while (beats_sent < BEAT_TARGET)
			run_phase();
		s_axis_tvalid <= 1'b0;

		// drain outstanding results, then let the block settle
		do @(posedge clk); while (results_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/pcbd_pkg.sv
hdl/pcbd_table.sv
hdl/pcbd_match.sv
hdl/prefix_code_bit_decoder.sv
tb/sv/prefix_code_bit_decoder_checker.sv
tb/sv/prefix_code_bit_decoder_tb.sv
